[rtl/json_stream_tokenizer_core_assert.svh]
// Assertion macros for the JSON tokenizer core
`ifndef JSON_STREAM_TOKENIZER_CORE_ASSERT_SVH
`define JSON_STREAM_TOKENIZER_CORE_ASSERT_SVH
// property a implies property b in the same cycle
`define JST_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// property a implies property b in the next cycle
`define JST_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[rtl/jst_pkg.sv]
// Package: types, constants and helpers of the JSON tokenizer
`timescale 1ns / 1ps
`default_nettype none
package jst_pkg;
  localparam int StackDepth = 32;
  localparam int ContentLimit = 256;
  localparam int SpW = $clog2(StackDepth + 1);
  localparam int SaW = $clog2(StackDepth);
  localparam int CcW = $clog2(ContentLimit + 2);

  typedef enum logic [3:0] {
    ST_START, ST_DONE, ST_ERROR, ST_IN_ARRAY, ST_IN_OBJECT, ST_END_KEY,
    ST_AFTER_KEY, ST_AFTER_VALUE, ST_IN_STRING, ST_ESCAPE, ST_UNICODE,
    ST_IN_NUMBER, ST_IN_TRUE, ST_IN_FALSE, ST_IN_NULL
  } state_t;

  typedef enum logic [1:0] {MK_ARRAY, MK_OBJECT, MK_KEY, MK_STRING} mark_t;

  localparam logic [3:0] EV_STARTDOC = 4'd0, EV_ENDDOC = 4'd1, EV_ARR_START = 4'd2,
    EV_ARR_END = 4'd3, EV_OBJ_START = 4'd4, EV_OBJ_END = 4'd5, EV_KEYBYTE = 4'd6,
    EV_ENDKEY = 4'd7, EV_STRBYTE = 4'd8, EV_ENDSTR = 4'd9, EV_NUMBYTE = 4'd10,
    EV_ENDNUM = 4'd11, EV_TRUE = 4'd12, EV_ERROR = 4'd15;

  localparam logic [3:0] ER_CTRL = 4'd0, ER_MEMBER = 4'd1, ER_COLON = 4'd2,
    ER_STRUCT = 4'd3, ER_ARRSEP = 4'd4, ER_INMARK = 4'd5, ER_DOT2 = 4'd6,
    ER_DOTEXP = 4'd7, ER_EXP2 = 4'd8, ER_SIGN = 4'd9, ER_FIRST = 4'd10,
    ER_ESC = 4'd11, ER_HEX = 4'd12, ER_LIT = 4'd13, ER_OVERFLOW = 4'd14;

  localparam logic [3:0] NF_DOT = 4'd1, NF_EXP = 4'd2, NF_NEG = 4'd4, NF_LASTE = 4'd8;

  typedef struct packed {
    logic [3:0] ev;
    logic [7:0] data;
    logic [1:0] kind;
    logic [3:0] err;
    logic       trunc;
    logic [5:0] depth;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } bundle_t;

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: case (i) 3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
              default: c = 8'h00; endcase
      2'd1: case (i) 3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
              3'd4: c = "e"; default: c = 8'h00; endcase
      default: case (i) 3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
              default: c = 8'h00; endcase
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

[rtl/json_stream_tokenizer_core.sv]
// Top level of the streaming JSON tokenizer
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | byte_in
//  out_    | output    | out_valid/out_stall| event and fields
//  cfg_    | input     | APB write          | restart_after_document
// One byte is taken per cycle when the output buffer will be empty after that cycle.
// A byte with several events holds the input off until its last event goes out (output port).
// Events appear in the cycle after the byte is taken.
// Reset is synchronous; the mark stack is not cleared.
// A stalled output holds the input off.
`timescale 1ns / 1ps
`default_nettype none
module json_stream_tokenizer_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_event_res,
  output logic [7:0]      out_data_byte,
  output logic [1:0]      out_number_kind,
  output logic [3:0]      out_error_code,
  output logic            out_truncated,
  output logic [5:0]      out_nesting_depth,
  output logic            out_last,
  input  wire logic       cfg_psel,
  input  wire logic       cfg_penable,
  input  wire logic       cfg_pwrite,
  input  wire logic [1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);
  import jst_pkg::*;
  `include "json_stream_tokenizer_core_assert.svh"

  state_t st_r, st_nxt;
  logic [SpW-1:0] sp_r, sp_nxt;
  logic [CcW-1:0] cc_r, cc_nxt;
  logic [3:0] nf_r, nf_nxt;
  logic [15:0] hacc_r, hacc_nxt;
  logic [2:0] hcnt_r, hcnt_nxt, lidx_r, lidx_nxt;
  logic lmis_r, lmis_nxt, restart_r, push, can_load, acc;
  mark_t push_mark, top;
  mark_t stk_r [StackDepth];
  bundle_t bnd;
  res_t res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, restart_r};
  assign in_stall = !can_load;
  assign acc = in_valid && can_load;
  assign top = (sp_r == '0) ? MK_ARRAY : stk_r[SaW'(sp_r - 1'b1)];

  jst_step u_step (
    .byte_in(in_byte_in), .restart(restart_r), .st(st_r), .sp(sp_r), .top(top),
    .cc(cc_r), .nf(nf_r), .hacc(hacc_r), .hcnt(hcnt_r), .lidx(lidx_r), .lmis(lmis_r),
    .st_nxt(st_nxt), .sp_nxt(sp_nxt), .cc_nxt(cc_nxt), .nf_nxt(nf_nxt),
    .hacc_nxt(hacc_nxt), .hcnt_nxt(hcnt_nxt), .lidx_nxt(lidx_nxt), .lmis_nxt(lmis_nxt),
    .push(push), .push_mark(push_mark), .bnd(bnd)
  );

  jst_outq u_outq (
    .clk(clk), .rst_n(rst_n), .load(acc), .bnd(bnd), .can_load(can_load),
    .out_valid(out_valid), .out_stall(out_stall), .res(res)
  );

  assign out_event_res = res.ev;
  assign out_data_byte = res.data;
  assign out_number_kind = res.kind;
  assign out_error_code = res.err;
  assign out_truncated = res.trunc;
  assign out_nesting_depth = res.depth;
  assign out_last = res.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_START; sp_r <= '0; cc_r <= '0; nf_r <= '0; hacc_r <= '0;
      hcnt_r <= '0; lidx_r <= '0; lmis_r <= 1'b0; restart_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
        restart_r <= cfg_pwdata[0];
      if (acc) begin
        st_r <= st_nxt; sp_r <= sp_nxt; cc_r <= cc_nxt; nf_r <= nf_nxt;
        hacc_r <= hacc_nxt; hcnt_r <= hcnt_nxt; lidx_r <= lidx_nxt; lmis_r <= lmis_nxt;
      end
    end
    if (acc && push) stk_r[SaW'(sp_r)] <= push_mark;
  end

  `JST_ASSERT_IMP(a_depth, 1'b1, sp_r <= SpW'(StackDepth))
  `JST_ASSERT_NXT(a_err_sticky, st_r == ST_ERROR, st_r == ST_ERROR)
  `JST_ASSERT_IMP(a_stall_busy, out_valid && out_stall, in_stall)
endmodule
`default_nettype wire

[rtl/jst_step.sv]
// Next-state and event logic for one input byte
`timescale 1ns / 1ps
`default_nettype none
module jst_step (
  input  wire logic [7:0]           byte_in,
  input  wire logic                 restart,
  input  wire jst_pkg::state_t      st,
  input  wire logic [jst_pkg::SpW-1:0] sp,
  input  wire jst_pkg::mark_t       top,
  input  wire logic [jst_pkg::CcW-1:0] cc,
  input  wire logic [3:0]           nf,
  input  wire logic [15:0]          hacc,
  input  wire logic [2:0]           hcnt,
  input  wire logic [2:0]           lidx,
  input  wire logic                 lmis,
  output jst_pkg::state_t           st_nxt,
  output logic [jst_pkg::SpW-1:0]   sp_nxt,
  output logic [jst_pkg::CcW-1:0]   cc_nxt,
  output logic [3:0]                nf_nxt,
  output logic [15:0]               hacc_nxt,
  output logic [2:0]                hcnt_nxt,
  output logic [2:0]                lidx_nxt,
  output logic                      lmis_nxt,
  output logic                      push,
  output jst_pkg::mark_t            push_mark,
  output jst_pkg::bundle_t          bnd
);
  import jst_pkg::*;
  localparam logic [CcW-1:0] LIM = CcW'(ContentLimit);
  localparam logic [CcW-1:0] LIM1 = CcW'(ContentLimit + 1);
  localparam logic [SpW-1:0] FULL = SpW'(StackDepth);

  res_t ra [3];
  logic [1:0] n;
  logic [7:0] c;
  logic ws, digit, ishex, tr, full, c_open, halt;
  logic [3:0] hv, sev;
  logic [15:0] cp;
  logic [2:0] llen, ni;
  logic [1:0] lk;
  logic [7:0] eb;
  logic eok;

  // combinational decode of the input byte: whitespace, digit, hex value and escape
  always_comb begin
    c = byte_in;
    ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
    digit = (c >= "0") && (c <= "9");
    tr = cc > LIM;
    full = sp >= FULL;
    sev = (sp != '0 && top == MK_KEY) ? EV_KEYBYTE : EV_STRBYTE;
    hv = 4'd0; ishex = 1'b1;
    if (digit) hv = c[3:0];
    else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) hv = c[3:0] + 4'd9;
    else ishex = 1'b0;
    cp = {hacc[11:0], hv};
    lk = (st == ST_IN_TRUE) ? 2'd0 : (st == ST_IN_FALSE) ? 2'd1 : 2'd2;
    llen = (lk == 2'd1) ? 3'd5 : 3'd4;
    eok = 1'b1; eb = c;
    case (c)
      "\"", "\\", "/": eb = c;
      "b": eb = 8'h08;
      "f": eb = 8'h0c;
      "n": eb = 8'h0a;
      "r": eb = 8'h0d;
      "t": eb = 8'h09;
      default: eok = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt = st; sp_nxt = sp; cc_nxt = cc; nf_nxt = nf; hacc_nxt = hacc;
    hcnt_nxt = hcnt; lidx_nxt = lidx; lmis_nxt = lmis;
    push = 1'b0; push_mark = MK_ARRAY; n = 2'd0; halt = 1'b0; c_open = 1'b0;
    ni = 3'd0;
    for (int i = 0; i < 3; i++) ra[i] = '0;

    if (st == ST_ERROR || st == ST_DONE) halt = 1'b1;
    else if (ws && st != ST_IN_STRING && st != ST_ESCAPE && st != ST_UNICODE &&
             st != ST_IN_NUMBER) halt = 1'b1;

    if (!halt) begin
      // phase 1: state-specific handling; c_open marks "start a value"
      unique case (st)
        ST_START: begin
          if (c == "[" || c == "{") begin
            ra[0].ev = EV_STARTDOC; ra[0].depth = 6'(sp); n = 2'd1; c_open = 1'b1;
          end
        end
        ST_IN_STRING: begin
          if (c == "\"") begin
            if (sp == '0) begin
              ra[0].ev = EV_ERROR; ra[0].err = ER_STRUCT; n = 2'd1; st_nxt = ST_ERROR;
            end else begin
              sp_nxt = sp - 1'b1; cc_nxt = '0;
              if (top == MK_KEY) begin
                ra[0].ev = EV_ENDKEY; ra[0].trunc = tr; st_nxt = ST_END_KEY;
              end else if (top == MK_STRING) begin
                ra[0].ev = EV_ENDSTR; ra[0].trunc = tr; st_nxt = ST_AFTER_VALUE;
              end else begin
                ra[0].ev = EV_ERROR; ra[0].err = ER_STRUCT; st_nxt = ST_ERROR;
              end
              ra[0].depth = 6'(sp - 1'b1); n = 2'd1;
            end
          end else if (c == "\\") st_nxt = ST_ESCAPE;
          else if (c <= 8'h1f || c == 8'h7f) begin
            ra[0].ev = EV_ERROR; ra[0].err = ER_CTRL; ra[0].depth = 6'(sp);
            n = 2'd1; st_nxt = ST_ERROR;
          end else if (cc < LIM) begin
            ra[0].ev = sev; ra[0].data = c; ra[0].depth = 6'(sp); n = 2'd1;
            cc_nxt = cc + 1'b1;
          end else cc_nxt = LIM1;
        end
        ST_ESCAPE: begin
          if (c == "u") begin
            hacc_nxt = '0; hcnt_nxt = '0; st_nxt = ST_UNICODE;
          end else if (!eok) begin
            ra[0].ev = EV_ERROR; ra[0].err = ER_ESC; ra[0].depth = 6'(sp);
            n = 2'd1; st_nxt = ST_ERROR;
          end else begin
            st_nxt = ST_IN_STRING;
            if (cc < LIM) begin
              ra[0].ev = sev; ra[0].data = eb; ra[0].depth = 6'(sp); n = 2'd1;
              cc_nxt = cc + 1'b1;
            end else cc_nxt = LIM1;
          end
        end
        ST_UNICODE: begin
          if (!ishex) begin
            ra[0].ev = EV_ERROR; ra[0].err = ER_HEX; ra[0].depth = 6'(sp);
            n = 2'd1; st_nxt = ST_ERROR;
          end else if (hcnt + 3'd1 >= 3'd4) begin
            hacc_nxt = '0; hcnt_nxt = '0; st_nxt = ST_IN_STRING;
            ra[0].ev = sev; ra[1].ev = sev;
            ra[0].depth = 6'(sp); ra[1].depth = 6'(sp);
            if (cp < 16'h0080 || cp >= 16'h0800) begin
              ra[0].data = (cp < 16'h0080) ? cp[7:0] : (cp == 16'h2019) ? 8'h27 : 8'h20;
              if (cc < LIM) begin n = 2'd1; cc_nxt = cc + 1'b1; end
              else cc_nxt = LIM1;
            end else begin
              ra[0].data = {3'b110, cp[10:6]};
              ra[1].data = {2'b10, cp[5:0]};
              if ({1'b0, cc} + (CcW + 1)'(2) <= {1'b0, LIM}) begin
                n = 2'd2; cc_nxt = cc + 2'd2;
              end else cc_nxt = LIM1;
            end
          end else begin
            hacc_nxt = cp; hcnt_nxt = hcnt + 3'd1;
          end
        end
        ST_IN_ARRAY: begin
          if (c != "]") c_open = 1'b1;
        end
        ST_IN_OBJECT: begin
          if (c == "\"") begin
            if (full) begin
              ra[0].ev = EV_ERROR; ra[0].err = ER_OVERFLOW; ra[0].depth = 6'(sp);
              n = 2'd1; st_nxt = ST_ERROR;
            end else begin
              push = 1'b1; push_mark = MK_KEY; sp_nxt = sp + 1'b1;
              cc_nxt = '0; st_nxt = ST_IN_STRING;
            end
          end else if (c != "}") begin
            ra[0].ev = EV_ERROR; ra[0].err = ER_MEMBER; ra[0].depth = 6'(sp);
            n = 2'd1; st_nxt = ST_ERROR;
          end
        end
        ST_END_KEY: begin
          if (c == ":") st_nxt = ST_AFTER_KEY;
          else begin
            ra[0].ev = EV_ERROR; ra[0].err = ER_COLON; ra[0].depth = 6'(sp);
            n = 2'd1; st_nxt = ST_ERROR;
          end
        end
        ST_AFTER_KEY: c_open = 1'b1;
        ST_AFTER_VALUE: ;
        ST_IN_NUMBER: begin
          if (digit) begin
            nf_nxt = nf & ~NF_LASTE;
            if (cc < LIM) begin
              ra[0].ev = EV_NUMBYTE; ra[0].data = c; ra[0].depth = 6'(sp); n = 2'd1;
              cc_nxt = cc + 1'b1;
            end else cc_nxt = LIM1;
          end else if (c == "." || c == "e" || c == "E" || c == "+" || c == "-") begin
            ra[0].ev = EV_ERROR; ra[0].depth = 6'(sp);
            if (c == "." && (nf & NF_DOT) != 0) ra[0].err = ER_DOT2;
            else if (c == "." && (nf & NF_EXP) != 0) ra[0].err = ER_DOTEXP;
            else if ((c == "e" || c == "E") && (nf & NF_EXP) != 0) ra[0].err = ER_EXP2;
            else if ((c == "+" || c == "-") && (nf & NF_LASTE) == 0) ra[0].err = ER_SIGN;
            else ra[0].ev = EV_NUMBYTE;
            if (ra[0].ev == EV_ERROR) begin
              n = 2'd1; st_nxt = ST_ERROR;
            end else begin
              if (c == ".") nf_nxt = (nf | NF_DOT) & ~NF_LASTE;
              else if (c == "e" || c == "E") nf_nxt = nf | NF_EXP | NF_LASTE;
              else nf_nxt = nf & ~NF_LASTE;
              if (cc < LIM) begin
                ra[0].data = c; n = 2'd1; cc_nxt = cc + 1'b1;
              end else cc_nxt = LIM1;
            end
          end else begin
            ra[0].ev = EV_ENDNUM; ra[0].depth = 6'(sp); ra[0].trunc = tr;
            ra[0].kind = ((nf & NF_DOT) != 0) ? 2'd2 : ((nf & NF_NEG) != 0) ? 2'd1 : 2'd0;
            n = 2'd1; cc_nxt = '0; nf_nxt = '0; st_nxt = ST_AFTER_VALUE;
          end
        end
        ST_IN_TRUE, ST_IN_FALSE, ST_IN_NULL: begin
          ni = lidx;
          if (lidx < llen) begin
            if (c != lit_char(lk, lidx)) lmis_nxt = 1'b1;
            ni = lidx + 3'd1; lidx_nxt = ni;
          end
          if (ni >= llen) begin
            ra[0].depth = 6'(sp); n = 2'd1;
            if (lmis_nxt) begin
              ra[0].ev = EV_ERROR; ra[0].err = ER_LIT; st_nxt = ST_ERROR;
            end else begin
              ra[0].ev = EV_TRUE + {2'b00, lk}; lidx_nxt = '0; st_nxt = ST_AFTER_VALUE;
            end
          end
        end
        default: ;
      endcase

      // phase 2: value start
      if (c_open) begin
        if (c == "[" || c == "{" || c == "\"") begin
          if (full) begin
            ra[n].ev = EV_ERROR; ra[n].err = ER_OVERFLOW; ra[n].depth = 6'(sp);
            n = n + 2'd1; st_nxt = ST_ERROR;
          end else begin
            push = 1'b1; sp_nxt = sp + 1'b1;
            if (c == "[") begin
              push_mark = MK_ARRAY; ra[n].ev = EV_ARR_START; st_nxt = ST_IN_ARRAY;
              ra[n].depth = 6'(sp + 1'b1); n = n + 2'd1;
            end else if (c == "{") begin
              push_mark = MK_OBJECT; ra[n].ev = EV_OBJ_START; st_nxt = ST_IN_OBJECT;
              ra[n].depth = 6'(sp + 1'b1); n = n + 2'd1;
            end else begin
              push_mark = MK_STRING; cc_nxt = '0; st_nxt = ST_IN_STRING;
            end
          end
        end else if (digit || c == "-") begin
          st_nxt = ST_IN_NUMBER; nf_nxt = (c == "-") ? NF_NEG : 4'd0;
          cc_nxt = CcW'(1); ra[n].ev = EV_NUMBYTE; ra[n].data = c; ra[n].depth = 6'(sp);
          n = n + 2'd1;
        end else if (c == "t" || c == "f" || c == "n") begin
          st_nxt = (c == "t") ? ST_IN_TRUE : (c == "f") ? ST_IN_FALSE : ST_IN_NULL;
          lidx_nxt = 3'd1; lmis_nxt = 1'b0;
        end else begin
          ra[n].ev = EV_ERROR; ra[n].err = ER_FIRST; ra[n].depth = 6'(sp);
          n = n + 2'd1; st_nxt = ST_ERROR;
        end
      end

      // phase 3: close or after-value handling
      if ((st == ST_AFTER_VALUE) || (st == ST_IN_NUMBER && st_nxt == ST_AFTER_VALUE && !ws) ||
          (st == ST_IN_ARRAY && c == "]") || (st == ST_IN_OBJECT && c == "}")) begin
        if (sp == '0) begin
          ra[n].ev = EV_ERROR; ra[n].err = ER_STRUCT; n = n + 2'd1; st_nxt = ST_ERROR;
        end else if ((st == ST_IN_ARRAY) || (st == ST_IN_OBJECT) ||
                     (top == MK_ARRAY && c == "]") || (top == MK_OBJECT && c == "}")) begin
          sp_nxt = sp - 1'b1;
          if ((c == "]" && top != MK_ARRAY) || (c == "}" && top != MK_OBJECT)) begin
            ra[n].ev = EV_ERROR; ra[n].err = ER_STRUCT; ra[n].depth = 6'(sp - 1'b1);
            n = n + 2'd1; st_nxt = ST_ERROR;
          end else begin
            ra[n].ev = (c == "]") ? EV_ARR_END : EV_OBJ_END;
            ra[n].depth = 6'(sp - 1'b1); n = n + 2'd1; st_nxt = ST_AFTER_VALUE;
            if (sp == SpW'(1)) begin
              ra[n].ev = EV_ENDDOC; n = n + 2'd1;
              if (restart) begin
                st_nxt = ST_START; cc_nxt = '0; nf_nxt = '0; hacc_nxt = '0;
                hcnt_nxt = '0; lidx_nxt = '0; lmis_nxt = 1'b0;
              end else st_nxt = ST_DONE;
            end
          end
        end else if (top == MK_OBJECT) begin
          if (c == ",") st_nxt = ST_IN_OBJECT;
        end else if (top == MK_ARRAY) begin
          if (c == ",") st_nxt = ST_IN_ARRAY;
          else begin
            ra[n].ev = EV_ERROR; ra[n].err = ER_ARRSEP; ra[n].depth = 6'(sp);
            n = n + 2'd1; st_nxt = ST_ERROR;
          end
        end else begin
          ra[n].ev = EV_ERROR; ra[n].err = ER_INMARK; ra[n].depth = 6'(sp);
          n = n + 2'd1; st_nxt = ST_ERROR;
        end
      end
    end

    if (n != 2'd0) ra[n - 2'd1].last = 1'b1;
    bnd.cnt = n;
    bnd.r0 = ra[0];
    bnd.r1 = ra[1];
    bnd.r2 = ra[2];
  end
endmodule
`default_nettype wire

[rtl/jst_outq.sv]
// Output buffer: holds one byte's events and hands them out one a cycle while out_stall is low
`timescale 1ns / 1ps
`default_nettype none
module jst_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire jst_pkg::bundle_t  bnd,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output jst_pkg::res_t          res
);
  import jst_pkg::*;
  res_t q_r [3];
  logic [1:0] rd_r, cnt_r;
  logic pop, empty_after;

  assign out_valid = cnt_r != rd_r;
  assign res = q_r[rd_r];
  assign pop = out_valid && !out_stall;
  assign empty_after = !out_valid || (pop && rd_r + 2'd1 == cnt_r);
  assign can_load = empty_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; cnt_r <= '0;
    end else if (load) begin
      rd_r <= '0; cnt_r <= bnd.cnt;
    end else if (pop) begin
      rd_r <= rd_r + 2'd1;
    end
    if (load) begin
      q_r[0] <= bnd.r0; q_r[1] <= bnd.r1; q_r[2] <= bnd.r2;
    end
  end
endmodule
`default_nettype wire
